// ===== hw/rtl/vlc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vlc_pkg: shared types and constants of the LEB128 varint codec
// Item and result formats, queue command format and back-end states.
// ============================================================================
package vlc_pkg;

    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned GROUP_W     = 7;
    localparam int unsigned SEEN_W      = 4;
    localparam int unsigned MAX_BYTES   = 10;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] CONT_MASK    = 8'h80;
    localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h7f;

    typedef enum logic
    {
        FUNC_ENCODE = 1'b0,
        FUNC_DECODE = 1'b1
    } func_t;

    typedef enum logic
    {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } cmd_kind_t;

    typedef enum logic
    {
        BK_IDLE   = 1'b0,
        BK_ENCODE = 1'b1
    } back_state_t;

    typedef struct packed
    {
        func_t              func;
        logic [VALUE_W-1:0] value;
        logic [BYTE_W-1:0]  in_byte;
    } vlc_in_t;

    typedef struct packed
    {
        logic               byte_valid;
        logic [BYTE_W-1:0]  out_byte;
        logic               value_valid;
        logic [VALUE_W-1:0] out_value;
        logic               decode_error;
        logic               last;
    } vlc_out_t;

    typedef struct packed
    {
        cmd_kind_t          kind;
        logic [VALUE_W-1:0] value;
        logic [GROUP_W-1:0] payload;
        logic               cont;
    } vlc_cmd_t;

endpackage

// ===== hw/rtl/vlc_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vlc_front: input acceptance and item classification
// Splits each item into an encode or decode command for the queue.
// ============================================================================
module vlc_front
    import vlc_pkg::*;
(
    input  logic     in_valid,
    output logic     in_ready,
    input  vlc_in_t  in_data,
    input  logic     queue_full,
    output logic     push,
    output vlc_cmd_t cmd
);

    logic [BYTE_W-1:0] masked_byte;

    assign in_ready    = !queue_full;
    assign push        = in_valid && !queue_full;
    assign masked_byte = in_data.in_byte & PAYLOAD_MASK;

    always_comb
    begin
        cmd.kind    = (in_data.func == FUNC_DECODE) ? CMD_DECODE : CMD_ENCODE;
        cmd.value   = in_data.value;
        cmd.payload = masked_byte[GROUP_W-1:0];
        cmd.cont    = |(in_data.in_byte & CONT_MASK);
    end

endmodule

// ===== hw/rtl/vlc_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vlc_queue: short command queue between front and back
// A small register FIFO so that each side can stall on its own.
// ============================================================================
module vlc_queue
    import vlc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  vlc_cmd_t push_cmd,
    input  logic     pop,
    output logic     full,
    output logic     not_empty,
    output vlc_cmd_t head
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    vlc_cmd_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");
`endif

endmodule

// ===== hw/rtl/vlc_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// vlc_back: command execution and result register
// Emits encoded bytes, one per unstalled cycle; folds decode bytes into value.
// ============================================================================
module vlc_back
    import vlc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    input  vlc_cmd_t head,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_ready,
    output vlc_out_t out_data
);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [VALUE_W-1:0] acc_reg;
    logic [VALUE_W-1:0] acc_next;
    logic [SEEN_W-1:0]  seen_reg;
    logic [SEEN_W-1:0]  seen_next;
    logic [VALUE_W-1:0] shift_reg;
    logic [VALUE_W-1:0] shift_next;
    logic               out_valid_reg;
    vlc_out_t           out_reg;

    logic               can_emit;
    logic               emit;
    vlc_out_t           res;
    logic [6:0]         shamt;
    logic [VALUE_W-1:0] shifted;
    logic               dec_err;
    logic               dec_has_result;
    logic               enc_more;

    assign can_emit       = !out_valid_reg || out_ready;
    assign shamt          = {seen_reg, 3'b000} - 7'(seen_reg);
    assign shifted        = VALUE_W'(head.payload) << shamt;
    assign dec_err        = (seen_reg >= SEEN_W'(MAX_BYTES))
                         || ((seen_reg == SEEN_W'(MAX_BYTES - 1)) && (head.payload > 7'd1));
    assign dec_has_result = dec_err || !head.cont;
    assign enc_more       = |shift_reg[VALUE_W-1:GROUP_W];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && (head.kind == CMD_ENCODE))
                begin
                    state_next = BK_ENCODE;
                end
            end
            BK_ENCODE:
            begin
                if (can_emit && !enc_more)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        pop        = 1'b0;
        emit       = 1'b0;
        res        = '0;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        shift_next = shift_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (head.kind == CMD_ENCODE)
                    begin
                        pop        = 1'b1;
                        shift_next = head.value;
                    end
                    else if (!dec_has_result || can_emit)
                    begin
                        pop = 1'b1;
                        if (dec_err)
                        begin
                            emit             = 1'b1;
                            res.decode_error = 1'b1;
                            res.last         = 1'b1;
                            acc_next         = '0;
                            seen_next        = '0;
                        end
                        else if (!head.cont)
                        begin
                            emit            = 1'b1;
                            res.value_valid = 1'b1;
                            res.out_value   = acc_reg | shifted;
                            res.last        = 1'b1;
                            acc_next        = '0;
                            seen_next       = '0;
                        end
                        else
                        begin
                            acc_next  = acc_reg | shifted;
                            seen_next = seen_reg + 1'b1;
                        end
                    end
                end
            end
            BK_ENCODE:
            begin
                if (can_emit)
                begin
                    emit           = 1'b1;
                    res.byte_valid = 1'b1;
                    res.out_byte   = {enc_more, shift_reg[GROUP_W-1:0]};
                    res.last       = !enc_more;
                    shift_next     = shift_reg >> GROUP_W;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            acc_reg       <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        if (emit)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef ASSERT_OFF
    a_no_pop_encoding: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_ENCODE) |-> !pop)
        else $error("queue popped during encode");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_W'(MAX_BYTES))
        else $error("byte count beyond ten");

    a_clear_after_value: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (res.value_valid || res.decode_error)) |=>
            ((seen_reg == '0) && (acc_reg == '0)))
        else $error("decode state not cleared after result");
`endif

endmodule

// ===== hw/rtl/varint_leb128_codec.sv =====
`timescale 1ns / 1ps
// ============================================================================
// varint_leb128_codec: unsigned 64-bit LEB128 varint encoder and decoder
// Front classifier, command queue and execution back end with result register.
// ============================================================================
// Usage:
// An input beat on in_valid/in_ready carries func, value and in_byte. With
// func at encode, the value leaves as 1 to 10 result beats on
// out_valid/out_ready, least significant 7-bit group first, with last set on
// the final byte. With func at decode, in_byte is folded into the running
// value; a continuation byte gives no result beat, a final byte gives one
// beat with value_valid, and an overlong or overflowing varint gives one beat
// with decode_error. Encodes leave a decode in progress untouched.
// Flow: a beat is written into a two-entry queue at acceptance; the back end
// takes it from the queue head once it is idle. A decode byte is popped
// unless it completes a result while the result register is held, and its
// result is registered. An encode loads the shift register and then emits
// one byte per unstalled cycle; the shift register sets the encode rate.
// A stalled out_ready holds the result register; the back end then waits and
// the queue fills, after which in_ready drops. Reset empties the queue,
// clears the decode accumulator and byte count and drops out_valid.
// ============================================================================
module varint_leb128_codec
    import vlc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  vlc_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output vlc_out_t out_data
);

    logic     push;
    logic     pop;
    logic     queue_full;
    logic     queue_not_empty;
    vlc_cmd_t push_cmd;
    vlc_cmd_t head_cmd;

    // Classification of each accepted beat into a queue command.
    vlc_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    // Decoupling queue so that a stalled receiver does not block acceptance
    // right away.
    vlc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_cmd)
    );

    // Execution: byte emission for encodes, accumulation for decodes.
    vlc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (queue_not_empty),
        .head      (head_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
